>>> hw/rtl/tcm_pkg.sv
// Package for the tritone color map: luma and blend constants, register indexes
// and helper functions. Used by every module of the block; depends on nothing.
package tcm_pkg;

    localparam int PIX_W  = 8;
    localparam int COLOR_W = 24;
    localparam int LUMA_W = 24;
    localparam int X_W    = 18;   // luma offset divided by 32
    localparam int QE_W   = 10;   // estimated quotient
    localparam int T_W    = 11;   // blend fraction 0..1024
    localparam int ACC_W  = 18;   // per-channel blend sum, at most 255*1024

    localparam logic [15:0] LUMA_COEF_R = 16'd19595;
    localparam logic [15:0] LUMA_COEF_G = 16'd38470;
    localparam logic [15:0] LUMA_COEF_B = 16'd7471;
    localparam logic [LUMA_W-1:0] LUMA_HALF = 24'd8355840;

    // t = floor(D / 8160) = floor(floor(D / 32) / 255).
    // floor(x / 255) is estimated as (x * 257) >> 16 and fixed with one step.
    localparam logic [8:0] RECIP_MUL = 9'd257;
    localparam int RECIP_SHIFT = 16;
    localparam logic [X_W:0] DIV_K = 19'd255;
    localparam logic [T_W-1:0] T_ONE = 11'd1024;

    localparam logic [COLOR_W-1:0] SHADOW_RESET    = 24'h330033;
    localparam logic [COLOR_W-1:0] MIDTONE_RESET   = 24'hB26633;
    localparam logic [COLOR_W-1:0] HIGHLIGHT_RESET = 24'hFFFFCC;

    typedef enum logic [1:0] {
        CFG_SHADOW    = 2'd0,
        CFG_MIDTONE   = 2'd1,
        CFG_HIGHLIGHT = 2'd2
    } t_cfg_idx;

    // Number of register stages from input item to result item.
    localparam int N_STAGES = 7;

    typedef logic [N_STAGES-1:0] t_stage_en;

    function automatic logic [PIX_W-1:0] chan_red(input logic [COLOR_W-1:0] c);
        return c[23:16];
    endfunction

    function automatic logic [PIX_W-1:0] chan_green(input logic [COLOR_W-1:0] c);
        return c[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] chan_blue(input logic [COLOR_W-1:0] c);
        return c[7:0];
    endfunction

endpackage

>>> hw/rtl/tcm_luma.sv
// Luma front end: three weighted products, their sum, and the segment split.
// Depends on tcm_pkg. Occupies pipeline stages one to three.
module tcm_luma (
    input  logic                      i_clk,
    input  logic [2:0]                i_en,
    input  logic [tcm_pkg::PIX_W-1:0] i_red,
    input  logic [tcm_pkg::PIX_W-1:0] i_green,
    input  logic [tcm_pkg::PIX_W-1:0] i_blue,
    output logic                      o_seg,
    output logic [tcm_pkg::X_W-1:0]   o_x
);

    logic [tcm_pkg::LUMA_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [tcm_pkg::LUMA_W-1:0] r_luma;
    logic                       r_seg;
    logic [tcm_pkg::X_W-1:0]    r_x;

    logic [tcm_pkg::LUMA_W-1:0] n_luma;
    logic                       n_seg;
    logic [tcm_pkg::LUMA_W-1:0] n_off;

    assign n_luma = r_prod_r + r_prod_g + r_prod_b;
    assign n_seg  = (r_luma >= tcm_pkg::LUMA_HALF);
    assign n_off  = n_seg ? (r_luma - tcm_pkg::LUMA_HALF) : r_luma;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod_r <= tcm_pkg::LUMA_W'(tcm_pkg::LUMA_COEF_R) * tcm_pkg::LUMA_W'(i_red);
            r_prod_g <= tcm_pkg::LUMA_W'(tcm_pkg::LUMA_COEF_G) * tcm_pkg::LUMA_W'(i_green);
            r_prod_b <= tcm_pkg::LUMA_W'(tcm_pkg::LUMA_COEF_B) * tcm_pkg::LUMA_W'(i_blue);
        end
        if (i_en[1]) begin
            r_luma <= n_luma;
        end
        if (i_en[2]) begin
            r_seg <= n_seg;
            // The offset stays below 2^23 in both segments.
            r_x   <= n_off[22:5];
        end
    end

    assign o_seg = r_seg;
    assign o_x   = r_x;

endmodule

>>> hw/rtl/tcm_tfrac.sv
// Blend fraction: divides the scaled luma offset by 255 with a reciprocal
// multiply and one correction step. Depends on tcm_pkg. Stages four and five.
module tcm_tfrac (
    input  logic                    i_clk,
    input  logic [1:0]              i_en,
    input  logic                    i_seg,
    input  logic [tcm_pkg::X_W-1:0] i_x,
    output logic                    o_seg,
    output logic [tcm_pkg::T_W-1:0] o_t
);

    logic                     r_seg_q, r_seg_t;
    logic [tcm_pkg::X_W-1:0]  r_x;
    logic [tcm_pkg::QE_W-1:0] r_qe;
    logic [tcm_pkg::T_W-1:0]  r_t;

    logic [26:0]              n_prod;
    logic [tcm_pkg::X_W:0]    n_rem;

    assign n_prod = 27'(i_x) * 27'(tcm_pkg::RECIP_MUL);
    // The estimate is the true quotient or one less, so the remainder is below 510.
    assign n_rem  = {1'b0, r_x} - 19'(r_qe) * tcm_pkg::DIV_K;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_seg_q <= i_seg;
            r_x     <= i_x;
            r_qe    <= n_prod[tcm_pkg::RECIP_SHIFT +: tcm_pkg::QE_W];
        end
        if (i_en[1]) begin
            r_seg_t <= r_seg_q;
            r_t     <= (n_rem >= tcm_pkg::DIV_K) ? tcm_pkg::T_W'(r_qe) + 11'd1
                                                  : tcm_pkg::T_W'(r_qe);
        end
    end

    assign o_seg = r_seg_t;
    assign o_t   = r_t;

endmodule

>>> hw/rtl/tcm_blend.sv
// Per-channel blend of two color stops and the output register.
// Depends on tcm_pkg. Stages six and seven.
module tcm_blend (
    input  logic                        i_clk,
    input  logic [1:0]                  i_en,
    input  logic                        i_seg,
    input  logic [tcm_pkg::T_W-1:0]     i_t,
    input  logic [tcm_pkg::COLOR_W-1:0] i_shadow,
    input  logic [tcm_pkg::COLOR_W-1:0] i_midtone,
    input  logic [tcm_pkg::COLOR_W-1:0] i_highlight,
    output logic [tcm_pkg::PIX_W-1:0]   o_red,
    output logic [tcm_pkg::PIX_W-1:0]   o_green,
    output logic [tcm_pkg::PIX_W-1:0]   o_blue
);

    logic [tcm_pkg::ACC_W-1:0] r_acc_r, r_acc_g, r_acc_b;
    logic [tcm_pkg::PIX_W-1:0] r_red, r_green, r_blue;

    logic [tcm_pkg::COLOR_W-1:0] n_lo, n_hi;
    logic [tcm_pkg::T_W-1:0]     n_tinv;

    assign n_lo   = i_seg ? i_midtone : i_shadow;
    assign n_hi   = i_seg ? i_highlight : i_midtone;
    assign n_tinv = tcm_pkg::T_ONE - i_t;

    function automatic logic [tcm_pkg::ACC_W-1:0] mix(
        input logic [tcm_pkg::PIX_W-1:0] c0,
        input logic [tcm_pkg::PIX_W-1:0] c1,
        input logic [tcm_pkg::T_W-1:0]   w0,
        input logic [tcm_pkg::T_W-1:0]   w1
    );
        return tcm_pkg::ACC_W'(c0) * tcm_pkg::ACC_W'(w0)
             + tcm_pkg::ACC_W'(c1) * tcm_pkg::ACC_W'(w1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_acc_r <= mix(tcm_pkg::chan_red(n_lo), tcm_pkg::chan_red(n_hi), n_tinv, i_t);
            r_acc_g <= mix(tcm_pkg::chan_green(n_lo), tcm_pkg::chan_green(n_hi),
                           n_tinv, i_t);
            r_acc_b <= mix(tcm_pkg::chan_blue(n_lo), tcm_pkg::chan_blue(n_hi), n_tinv, i_t);
        end
        if (i_en[1]) begin
            // The weights sum to 1024, so the scaled sum never exceeds 255.
            r_red   <= r_acc_r[tcm_pkg::ACC_W-1:10];
            r_green <= r_acc_g[tcm_pkg::ACC_W-1:10];
            r_blue  <= r_acc_b[tcm_pkg::ACC_W-1:10];
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

>>> hw/rtl/tritone_color_map.sv
// Top level of the tritone color map: configuration registers, pipeline control
// and the three datapath sections. Depends on tcm_pkg, tcm_luma, tcm_tfrac, tcm_blend.
//
// Usage. An input item is one RGB pixel on i_red_in, i_green_in and i_blue_in,
// taken when i_valid and o_ready are both high. A result item is the mapped pixel
// on o_red_out, o_green_out and o_blue_out, taken when o_valid and i_ready are high.
// The pixel's BT.601 luma picks the shadow-to-midtone or midtone-to-highlight
// segment and an 11-bit blend fraction; each channel is blended between two stops.
// The item passes seven register stages before its result shows on the outputs.
// Throughput is one item per cycle while the receiver keeps i_ready high, set by
// the seven-stage pipeline in which every stage holds its own valid bit.
// When the receiver stalls, each stage holds while the stage after it is full
// and stalled, so empty stages keep filling; o_ready falls only once the
// whole pipeline is full. Nothing is dropped or repeated. Reset (synchronous,
// i_rst_n low) empties the pipeline and loads the default colors. The colors are
// written through i_cfg_we, i_cfg_idx and i_cfg_data while the block is idle;
// the block does not enforce this. An index past the highlight register is ignored.
module tritone_color_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tcm_pkg::PIX_W-1:0]   i_red_in,
    input  logic [tcm_pkg::PIX_W-1:0]   i_green_in,
    input  logic [tcm_pkg::PIX_W-1:0]   i_blue_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tcm_pkg::PIX_W-1:0]   o_red_out,
    output logic [tcm_pkg::PIX_W-1:0]   o_green_out,
    output logic [tcm_pkg::PIX_W-1:0]   o_blue_out,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [tcm_pkg::COLOR_W-1:0] i_cfg_data
);

    // Color stops.
    logic [tcm_pkg::COLOR_W-1:0] r_shadow, r_midtone, r_highlight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= tcm_pkg::SHADOW_RESET;
            r_midtone   <= tcm_pkg::MIDTONE_RESET;
            r_highlight <= tcm_pkg::HIGHLIGHT_RESET;
        end else if (i_cfg_we) begin
            case (tcm_pkg::t_cfg_idx'(i_cfg_idx))
                tcm_pkg::CFG_SHADOW:    r_shadow    <= i_cfg_data;
                tcm_pkg::CFG_MIDTONE:   r_midtone   <= i_cfg_data;
                tcm_pkg::CFG_HIGHLIGHT: r_highlight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control. A stage loads when it is empty or when the stage after it
    // loads too; the last stage is the output register.
    tcm_pkg::t_stage_en        stage_en;
    logic [tcm_pkg::N_STAGES-1:0] r_valid;
    logic [tcm_pkg::N_STAGES-1:0] n_valid;

    always_comb begin
        stage_en[tcm_pkg::N_STAGES-1] = !r_valid[tcm_pkg::N_STAGES-1] || i_ready;
        for (int k = tcm_pkg::N_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid[0] = stage_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < tcm_pkg::N_STAGES; k++) begin
            n_valid[k] = stage_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = stage_en[0];
    assign o_valid = r_valid[tcm_pkg::N_STAGES-1];

    // Datapath.
    logic                      luma_seg;
    logic [tcm_pkg::X_W-1:0]   luma_x;
    logic                      frac_seg;
    logic [tcm_pkg::T_W-1:0]   frac_t;

    tcm_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (stage_en[2:0]),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_seg   (luma_seg),
        .o_x     (luma_x)
    );

    tcm_tfrac u_tfrac (
        .i_clk (i_clk),
        .i_en  (stage_en[4:3]),
        .i_seg (luma_seg),
        .i_x   (luma_x),
        .o_seg (frac_seg),
        .o_t   (frac_t)
    );

    tcm_blend u_blend (
        .i_clk       (i_clk),
        .i_en        (stage_en[6:5]),
        .i_seg       (frac_seg),
        .i_t         (frac_t),
        .i_shadow    (r_shadow),
        .i_midtone   (r_midtone),
        .i_highlight (r_highlight),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out)
    );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for tritone_color_map: directed and random pixels,
// register writes between phases, and random idling on both channels.
// Depends on tcm_pkg and the tritone_color_map RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is far shorter than this. Every item is delayed only by the sender's
    // idle gap, the receiver's stall and the pipeline depth.
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Luma weights in Q16 and the segment geometry of the gradient.
    localparam logic [31:0] WEIGHT_RED   = 32'd19595;
    localparam logic [31:0] WEIGHT_GREEN = 32'd38470;
    localparam logic [31:0] WEIGHT_BLUE  = 32'd7471;
    localparam logic [31:0] HALF_LUMA    = 32'd8355840;
    localparam logic [31:0] FRAC_STEP    = 32'd8160;
    localparam logic [31:0] FRAC_ONE     = 32'd1024;

    // The index after the highlight register selects nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [tcm_pkg::PIX_W-1:0] red;
        logic [tcm_pkg::PIX_W-1:0] green;
        logic [tcm_pkg::PIX_W-1:0] blue;
    } t_pixel;

    // Clock, reset and every block input start at a known value.
    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    logic                        i_ready    = 1'b0;
    logic [tcm_pkg::PIX_W-1:0]   i_red_in   = '0;
    logic [tcm_pkg::PIX_W-1:0]   i_green_in = '0;
    logic [tcm_pkg::PIX_W-1:0]   i_blue_in  = '0;
    logic                        i_cfg_we   = 1'b0;
    logic [1:0]                  i_cfg_idx  = '0;
    logic [tcm_pkg::COLOR_W-1:0] i_cfg_data = '0;
    logic                        o_ready;
    logic                        o_valid;
    logic [tcm_pkg::PIX_W-1:0]   o_red_out;
    logic [tcm_pkg::PIX_W-1:0]   o_green_out;
    logic [tcm_pkg::PIX_W-1:0]   o_blue_out;

    // Our own copy of the three color stops, kept in step with every write.
    logic [tcm_pkg::COLOR_W-1:0] shadow_stop    = tcm_pkg::SHADOW_RESET;
    logic [tcm_pkg::COLOR_W-1:0] midtone_stop   = tcm_pkg::MIDTONE_RESET;
    logic [tcm_pkg::COLOR_W-1:0] highlight_stop = tcm_pkg::HIGHLIGHT_RESET;

    // Mapped pixels still owed by the block, oldest first.
    t_pixel mapped_pixels[$];

    int  error_count  = 0;
    int  result_count = 0;
    int  cycle_count  = 0;
    // When cleared, both sides run without idle cycles.
    bit  idling_on    = 1'b1;

    tritone_color_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Blend one channel between two stops with a Q1.10 fraction, truncate and
    // clamp to the pixel range.
    function automatic logic [tcm_pkg::PIX_W-1:0] blend_chan(
        input logic [tcm_pkg::PIX_W-1:0] c0,
        input logic [tcm_pkg::PIX_W-1:0] c1,
        input logic [31:0]               frac
    );
        logic [31:0] sum;
        sum = 32'(c0) * (FRAC_ONE - frac) + 32'(c1) * frac;
        sum = sum >> 10;
        return (sum > 32'd255) ? 8'd255 : sum[tcm_pkg::PIX_W-1:0];
    endfunction

    // Predict the mapped pixel with the current color stops. The luma picks the
    // segment; the offset into that segment gives the blend fraction.
    function automatic t_pixel map_pixel(input t_pixel px);
        logic [31:0]                 luma;
        logic [31:0]                 frac;
        logic [tcm_pkg::COLOR_W-1:0] lo_stop;
        logic [tcm_pkg::COLOR_W-1:0] hi_stop;
        t_pixel                      res;
        luma = WEIGHT_RED * 32'(px.red) + WEIGHT_GREEN * 32'(px.green)
             + WEIGHT_BLUE * 32'(px.blue);
        if (luma < HALF_LUMA) begin
            lo_stop = shadow_stop;
            hi_stop = midtone_stop;
            frac    = luma / FRAC_STEP;
        end else begin
            lo_stop = midtone_stop;
            hi_stop = highlight_stop;
            frac    = (luma - HALF_LUMA) / FRAC_STEP;
        end
        if (frac > FRAC_ONE) frac = FRAC_ONE;
        res.red   = blend_chan(lo_stop[23:16], hi_stop[23:16], frac);
        res.green = blend_chan(lo_stop[15:8],  hi_stop[15:8],  frac);
        res.blue  = blend_chan(lo_stop[7:0],   hi_stop[7:0],   frac);
        return res;
    endfunction

    // Search all pixels for the one whose luma lies closest to the half-scale
    // split, either at or above it, or strictly below it. If a pixel hits the
    // split exactly, the search from above returns it.
    function automatic t_pixel pixel_near_half(input bit from_above);
        int     rest;
        int     b;
        int     luma;
        int     best;
        t_pixel found;
        best  = from_above ? 32'h7fffffff : -1;
        found = '0;
        for (int r = 0; r < 256; r++) begin
            for (int g = 0; g < 256; g++) begin
                rest = int'(HALF_LUMA) - 19595 * r - 38470 * g;
                if (from_above) begin
                    b = (rest <= 0) ? 0 : (rest + 7470) / 7471;
                end else begin
                    b = (rest <= 0) ? -1 : (rest - 1) / 7471;
                    if (b > 255) b = 255;
                end
                if (b >= 0 && b <= 255) begin
                    luma = 19595 * r + 38470 * g + 7471 * b;
                    if (from_above ? (luma < best) : (luma > best)) begin
                        best  = luma;
                        found = {8'(r), 8'(g), 8'(b)};
                    end
                end
            end
        end
        return found;
    endfunction

    // Present one input item after a random idle gap and wait until the block
    // takes it. Valid is only lowered when a gap follows, so back-to-back items
    // keep it high without a second assignment in the same time step.
    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = idling_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        do @(posedge i_clk); while (!o_ready);
        mapped_pixels.push_back(map_pixel(px));
    endtask

    // Drop valid and wait until every owed result has come out, then let the
    // pipeline run empty for its full depth before anything else happens.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (mapped_pixels.size() != 0) @(posedge i_clk);
        repeat (tcm_pkg::N_STAGES + 2) @(posedge i_clk);
    endtask

    // Write one color register and mirror the write in our copy. An unused
    // index must leave every register unchanged.
    task automatic write_color(input logic [1:0] idx,
                               input logic [tcm_pkg::COLOR_W-1:0] color);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= color;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tcm_pkg::CFG_SHADOW:    shadow_stop    = color;
            tcm_pkg::CFG_MIDTONE:   midtone_stop   = color;
            tcm_pkg::CFG_HIGHLIGHT: highlight_stop = color;
            default: ;
        endcase
    endtask

    function automatic logic [tcm_pkg::COLOR_W-1:0] random_color();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return tcm_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    // Random pixels: mostly uniform, some near gray where the luma sweeps the
    // whole gradient evenly, some close to the split, some at channel extremes.
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     level;
        case ($urandom_range(0, 9))
            6, 7: begin
                level = $urandom_range(0, 255);
                px.red   = 8'(level);
                px.green = 8'(level);
                px.blue  = 8'(level);
                px.red   = px.red ^ 8'($urandom_range(0, 3));
                px.blue  = px.blue ^ 8'($urandom_range(0, 3));
            end
            8: begin
                px.red   = 8'($urandom_range(124, 131));
                px.green = 8'($urandom_range(124, 131));
                px.blue  = 8'($urandom_range(124, 131));
            end
            9: begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: px = t_pixel'(24'($urandom));
        endcase
        return px;
    endfunction

    // Pixels at the ends of the gradient, on both sides of the split, and with
    // single channels driven to their extremes, all with the reset colors.
    task automatic test_default_colors();
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'hFF, 8'h00, 8'h00});
        send_pixel('{8'h00, 8'hFF, 8'h00});
        send_pixel('{8'h00, 8'h00, 8'hFF});
        send_pixel(pixel_near_half(1'b0));
        send_pixel(pixel_near_half(1'b1));
        send_pixel('{8'h40, 8'h40, 8'h40});
        send_pixel('{8'hAA, 8'h55, 8'hAA});
        send_pixel('{8'h55, 8'hAA, 8'h55});
        drain_pipeline();
    endtask

    // Extreme and inverted stops, then a write to the unused index which must
    // not disturb the highlight stop.
    task automatic test_register_writes();
        write_color(tcm_pkg::CFG_SHADOW,    24'h000000);
        write_color(tcm_pkg::CFG_MIDTONE,   24'hFFFFFF);
        write_color(tcm_pkg::CFG_HIGHLIGHT, 24'h000000);
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel(pixel_near_half(1'b0));
        send_pixel(pixel_near_half(1'b1));
        send_pixel('{8'hC0, 8'hC0, 8'hC0});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        drain_pipeline();
        write_color(CFG_UNUSED, 24'hFFFFFF);
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'h80, 8'h80, 8'h80});
        drain_pipeline();
        write_color(tcm_pkg::CFG_SHADOW,    24'hFFFFFF);
        write_color(tcm_pkg::CFG_MIDTONE,   24'h00FF00);
        write_color(tcm_pkg::CFG_HIGHLIGHT, 24'hFFFFFF);
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'h60, 8'h20, 8'hE0});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        drain_pipeline();
    endtask

    // Random pixels in phases, each with a fresh set of stops. Some phases run
    // without idling on either side, so the pipeline fills and the sender sees no
    // backpressure at all.
    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            write_color(tcm_pkg::CFG_SHADOW,    random_color());
            write_color(tcm_pkg::CFG_MIDTONE,   random_color());
            write_color(tcm_pkg::CFG_HIGHLIGHT, random_color());
            if ($urandom_range(0, 3) == 0) write_color(CFG_UNUSED, random_color());
            idling_on = (phase % 3) != 1;
            for (int n = 0; n < 65; n++) send_pixel(random_pixel());
            drain_pipeline();
        end
        idling_on = 1'b1;
    endtask

    // Receiver side: a random stall before each result, or none at all while
    // idling is off. Ready is lowered only when a stall follows.
    initial begin : result_sink
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idling_on ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Every result taken is compared with the oldest owed pixel.
    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (mapped_pixels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result %0d: %02h %02h %02h", result_count,
                             o_red_out, o_green_out, o_blue_out);
            end else begin
                want = mapped_pixels.pop_front();
                if (o_red_out !== want.red || o_green_out !== want.green ||
                    o_blue_out !== want.blue) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch on result %0d: expected %02h %02h %02h,",
                                  " got %02h %02h %02h"},
                                 result_count, want.red, want.green, want.blue,
                                 o_red_out, o_green_out, o_blue_out);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Reset once, run the tests in turn, then settle and report.
    initial begin : test_sequence
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_colors();
        test_register_writes();
        test_random_stream();
        drain_pipeline();
        repeat (2 * tcm_pkg::N_STAGES) @(posedge i_clk);
        if (mapped_pixels.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
